// ----- hdl/differential_drive_duty_mixer_assert.svh -----
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef DIFFERENTIAL_DRIVE_DUTY_MIXER_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_DUTY_MIXER_ASSERT_SVH

// same-cycle implication
`define DDMIX_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DDMIX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ddmix_pkg.sv -----
package ddmix_pkg;

  localparam int DUTY_BITS = 30;

  typedef logic [DUTY_BITS-1:0] duty_t;

  typedef enum logic [1:0] {
    OP_STOP,
    OP_DRIVE,
    OP_HARD_TURN,
    OP_BANK_TURN
  } op_t;

  typedef enum logic [1:0] {
    DIR_FORWARD,
    DIR_BACKWARD,
    DIR_LEFT,
    DIR_RIGHT
  } dir_t;

  typedef struct packed {
    op_t  op;
    dir_t dir;
    logic amt_zero;
    logic g_pos;
    logic g_neg;
  } ctl_t;

  localparam duty_t PERIOD_RESET = 30'd1000000;
  localparam duty_t DUTY_RESET   = 30'd500000;
  localparam logic [6:0] AMOUNT_MAX = 7'd100;

  // floor(x / 100) = (x * R) >> 36 for x below 2^29
  localparam logic [29:0] RECIP_100_WIDE = 30'd687194768;
  // floor(x / 100) = (x * R) >> 22 for x below 2^15
  localparam logic [15:0] RECIP_100_NARROW = 16'd41944;
  // floor(x / 200) = (x * R) >> 38 for x below 2^30
  localparam logic [30:0] RECIP_200_WIDE = 31'd1374389535;
  // floor(x / 200) = (x * R) >> 24 for x below 2^16
  localparam logic [16:0] RECIP_200_NARROW = 17'd83887;

endpackage

// ----- hdl/differential_drive_duty_mixer.sv -----
// latency: an accepted input beat passes through the stage registers and then the output register
// throughput: one beat per cycle while the output is not stalled; a bank turn waits in the
//   first stage until all earlier commands have written the duties back
// reset: rst is synchronous; period goes to 1000000, both duties to 500000,
//   pipeline and output emptied
module differential_drive_duty_mixer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [29:0] cfg_data,       // pwm_period
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // amount[6:0], direction[8:7], zero fill
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // duty_left[29:0], duty_right[59:30], zero fill
  output logic        m_axis_tuser    // set when the command was ignored
);

  ddmix_pkg::duty_t period;
  logic [28:0]      half;
  logic [22:0]      hq;
  logic [6:0]       hr;
  logic [58:0]      hq_prod;

  ddmix_pkg::duty_t left_duty;
  ddmix_pkg::duty_t right_duty;

  logic [8:1]       vld;
  logic [9:2]       en;
  logic             bank_hold;
  logic             s1_take;
  ddmix_pkg::ctl_t  ctl [1:8];
  logic [6:0]       amt_in;
  logic [6:0]       s1_amt;

  logic signed [30:0] s2_dl, s2_dr;
  logic [7:0]  s2_kp, s2_km;
  logic [8:0]  s2_kr, s2_kf;
  logic [29:0] al, ar;

  logic [29:0] s3_hqp, s3_hqm, s3_m;
  logic [14:0] s3_hrp, s3_hrm;
  logic [8:0]  s3_kr, s3_kf;
  logic [29:0] qp_prod, qm_prod;
  logic [60:0] m_prod;

  logic [29:0] s4_hqp, s4_hqm, s4_m;
  logic [7:0]  s4_qp, s4_qm;
  logic [22:0] s4_c;
  logic [8:0]  s4_kr, s4_kf;

  logic [29:0] s5_dp, s5_dm;
  logic [22:0] s5_c;
  logic [7:0]  s5_d;
  logic [8:0]  s5_kr, s5_kf;

  logic [29:0] s6_dp, s6_dm;
  logic [30:0] s6_ckr, s6_ckf;
  logic [15:0] s6_dkr, s6_dkf;
  logic [32:0] qr_prod, qf_prod;

  logic [29:0] s7_dp, s7_dm;
  logic [30:0] s7_ckr, s7_ckf;
  logic [15:0] s7_dkr, s7_dkf;
  logic [8:0]  s7_qr, s7_qf;
  logic        inexact_r, inexact_f;

  logic [29:0] s8_dp, s8_dm;
  logic [30:0] s8_tr, s8_tf;

  ddmix_pkg::duty_t left_next, right_next, bank_r, bank_f;
  logic             ign_next;

  function automatic ddmix_pkg::duty_t bank_duty(input logic [28:0] h, input logic up,
                                                 input logic [30:0] t,
                                                 input ddmix_pkg::duty_t lim);
    logic [31:0] v;
    if (up) begin
      v = {3'b000, h} + {1'b0, t};
    end else if ({2'b00, h} < t) begin
      v = '0;
    end else begin
      v = {3'b000, h} - {1'b0, t};
    end
    if (v > {2'b00, lim}) begin
      return lim;
    end
    return v[29:0];
  endfunction

  // period register and its derived half / 100 split
  assign half = period[29:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= ddmix_pkg::PERIOD_RESET;
    end else if (cfg_write) begin
      period <= cfg_data;
    end
  end

  always_comb begin
    hq_prod = half * ddmix_pkg::RECIP_100_WIDE;
  end

  always_ff @(posedge clk) begin
    hq <= hq_prod[58:36];
    hr <= 7'(half - 29'(hq) * 29'd100);
  end

  // stage enables, each stage moves when the next one is free or moving
  always_comb begin
    en[9] = !m_axis_tvalid || m_axis_tready;
    for (int i = 8; i >= 2; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  // a bank turn reads the stored duties, so everything ahead must be written back
  assign bank_hold     = (ctl[1].op == ddmix_pkg::OP_BANK_TURN) && (vld[8:2] != '0);
  assign s1_take       = !vld[1] || (!bank_hold && en[2]);
  assign s_axis_tready = s1_take;
  assign amt_in = (s_axis_tdata[6:0] > ddmix_pkg::AMOUNT_MAX) ? ddmix_pkg::AMOUNT_MAX
                                                              : s_axis_tdata[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= '0;
      m_axis_tvalid <= 1'b0;
      left_duty     <= ddmix_pkg::DUTY_RESET;
      right_duty    <= ddmix_pkg::DUTY_RESET;
    end else begin
      if (s1_take) begin
        vld[1] <= s_axis_tvalid;
      end
      if (en[2]) begin
        vld[2] <= vld[1] && !bank_hold;
      end
      for (int i = 3; i <= 8; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
      if (en[9]) begin
        m_axis_tvalid <= vld[8];
        if (vld[8]) begin
          left_duty  <= left_next;
          right_duty <= right_next;
        end
      end
    end
  end

  // datapath combinational pieces
  always_comb begin
    al = s2_dl[30] ? 30'(-s2_dl) : 30'(s2_dl);
    ar = s2_dr[30] ? 30'(-s2_dr) : 30'(s2_dr);
    qp_prod = s3_hrp * ddmix_pkg::RECIP_100_NARROW;
    qm_prod = s3_hrm * ddmix_pkg::RECIP_100_NARROW;
    m_prod  = s3_m * ddmix_pkg::RECIP_200_WIDE;
    qr_prod = s6_dkr * ddmix_pkg::RECIP_200_NARROW;
    qf_prod = s6_dkf * ddmix_pkg::RECIP_200_NARROW;
    inexact_r = (s7_dkr - 16'(s7_qr) * 16'd200) != '0;
    inexact_f = (s7_dkf - 16'(s7_qf) * 16'd200) != '0;
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      ctl[1].op       <= ddmix_pkg::op_t'(s_axis_tuser);
      ctl[1].dir      <= ddmix_pkg::dir_t'(s_axis_tdata[8:7]);
      ctl[1].amt_zero <= amt_in == '0;
      ctl[1].g_pos    <= 1'b0;
      ctl[1].g_neg    <= 1'b0;
      s1_amt          <= amt_in;
    end
    if (en[2]) begin
      ctl[2] <= ctl[1];
      s2_dl  <= $signed({1'b0, left_duty}) - $signed({2'b00, half});
      s2_dr  <= $signed({1'b0, right_duty}) - $signed({2'b00, half});
      s2_kp  <= 8'(8'd100 + 8'(s1_amt));
      s2_km  <= 8'(8'd100 - 8'(s1_amt));
      s2_kr  <= 9'(9'd200 - 9'(s1_amt));
      s2_kf  <= 9'(9'd200 + 9'(s1_amt));
    end
    if (en[3]) begin
      ctl[3].op       <= ctl[2].op;
      ctl[3].dir      <= ctl[2].dir;
      ctl[3].amt_zero <= ctl[2].amt_zero;
      ctl[3].g_pos    <= !s2_dl[30] && (s2_dl != '0) && !s2_dr[30] && (s2_dr != '0);
      ctl[3].g_neg    <= s2_dl[30] && s2_dr[30];
      s3_hqp <= 30'(hq) * 30'(s2_kp);
      s3_hqm <= 30'(hq) * 30'(s2_km);
      s3_hrp <= 15'(hr) * 15'(s2_kp);
      s3_hrm <= 15'(hr) * 15'(s2_km);
      s3_m   <= (al < ar) ? al : ar;
      s3_kr  <= s2_kr;
      s3_kf  <= s2_kf;
    end
    if (en[4]) begin
      ctl[4] <= ctl[3];
      s4_hqp <= s3_hqp;
      s4_hqm <= s3_hqm;
      s4_qp  <= qp_prod[29:22];
      s4_qm  <= qm_prod[29:22];
      s4_c   <= m_prod[60:38];
      s4_m   <= s3_m;
      s4_kr  <= s3_kr;
      s4_kf  <= s3_kf;
    end
    if (en[5]) begin
      ctl[5] <= ctl[4];
      s5_dp  <= 30'(s4_hqp + 30'(s4_qp));
      s5_dm  <= 30'(s4_hqm + 30'(s4_qm));
      s5_c   <= s4_c;
      s5_d   <= 8'(s4_m - 30'(s4_c) * 30'd200);
      s5_kr  <= s4_kr;
      s5_kf  <= s4_kf;
    end
    if (en[6]) begin
      ctl[6] <= ctl[5];
      s6_dp  <= s5_dp;
      s6_dm  <= s5_dm;
      s6_ckr <= 31'(s5_c) * 31'(s5_kr);
      s6_ckf <= 31'(s5_c) * 31'(s5_kf);
      s6_dkr <= 16'(s5_d) * 16'(s5_kr);
      s6_dkf <= 16'(s5_d) * 16'(s5_kf);
    end
    if (en[7]) begin
      ctl[7] <= ctl[6];
      s7_dp  <= s6_dp;
      s7_dm  <= s6_dm;
      s7_ckr <= s6_ckr;
      s7_ckf <= s6_ckf;
      s7_dkr <= s6_dkr;
      s7_dkf <= s6_dkf;
      s7_qr  <= qr_prod[32:24];
      s7_qf  <= qf_prod[32:24];
    end
    if (en[8]) begin
      ctl[8] <= ctl[7];
      s8_dp  <= s7_dp;
      s8_dm  <= s7_dm;
      // a falling bank rounds the magnitude up
      s8_tr  <= 31'(s7_ckr + 31'(s7_qr) + 31'(ctl[7].g_neg && inexact_r));
      s8_tf  <= 31'(s7_ckf + 31'(s7_qf) + 31'(ctl[7].g_neg && inexact_f));
    end
    if (en[9] && vld[8]) begin
      m_axis_tdata <= {4'b0000, right_next, left_next};
      m_axis_tuser <= ign_next;
    end
  end

  // final selection, written back to the stored duties
  always_comb begin
    bank_r     = bank_duty(half, ctl[8].g_pos, s8_tr, period);
    bank_f     = bank_duty(half, ctl[8].g_pos, s8_tf, period);
    left_next  = left_duty;
    right_next = right_duty;
    ign_next   = 1'b0;
    case (ctl[8].op)
      ddmix_pkg::OP_STOP: begin
        left_next  = {1'b0, half};
        right_next = {1'b0, half};
      end
      ddmix_pkg::OP_DRIVE: begin
        case (ctl[8].dir)
          ddmix_pkg::DIR_FORWARD: begin
            left_next  = s8_dm;
            right_next = s8_dm;
          end
          ddmix_pkg::DIR_BACKWARD: begin
            left_next  = s8_dp;
            right_next = s8_dp;
          end
          default: ign_next = 1'b1;
        endcase
      end
      ddmix_pkg::OP_HARD_TURN: begin
        case (ctl[8].dir)
          ddmix_pkg::DIR_RIGHT: begin
            left_next  = s8_dp;
            right_next = s8_dm;
          end
          ddmix_pkg::DIR_LEFT: begin
            left_next  = s8_dm;
            right_next = s8_dp;
          end
          default: ign_next = 1'b1;
        endcase
      end
      ddmix_pkg::OP_BANK_TURN: begin
        if (!(ctl[8].g_pos || ctl[8].g_neg) || ctl[8].amt_zero ||
            ctl[8].dir inside {ddmix_pkg::DIR_FORWARD, ddmix_pkg::DIR_BACKWARD}) begin
          ign_next = 1'b1;
        end else if (ctl[8].dir == ddmix_pkg::DIR_RIGHT) begin
          left_next  = bank_r;
          right_next = bank_f;
        end else begin
          left_next  = bank_f;
          right_next = bank_r;
        end
      end
      default: ign_next = 1'b1;
    endcase
  end

`include "differential_drive_duty_mixer_assert.svh"

  `DDMIX_ASSERT_IMPLY(a_out_matches_state, m_axis_tvalid, m_axis_tdata[29:0] == left_duty && m_axis_tdata[59:30] == right_duty, "result beat differs from stored duties")
  `DDMIX_ASSERT_NEXT(a_ignored_keeps_state, en[9] && vld[8] && ign_next, left_duty == $past(left_duty) && right_duty == $past(right_duty), "ignored command changed duties")
  `DDMIX_ASSERT_NEXT(a_bank_runs_alone, en[2] && vld[1] && !bank_hold && ctl[1].op == ddmix_pkg::OP_BANK_TURN, vld[8:3] == 6'd0, "bank turn overlapped earlier command")

endmodule
